// ===== hw/rtl/nls_pkg.sv =====
// Shared types, codes and character classes for the numeric literal scanner.
package nls_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 255;

  // Token kinds as they appear on the result channel.
  localparam logic [2:0] KIND_INT      = 3'd0;
  localparam logic [2:0] KIND_FLOAT    = 3'd1;
  localparam logic [2:0] KIND_BAD_HEX  = 3'd2;
  localparam logic [2:0] KIND_BAD_BIN  = 3'd3;
  localparam logic [2:0] KIND_BAD_ZERO = 3'd4;
  localparam logic [2:0] KIND_BAD_EXP  = 3'd5;

  localparam logic [1:0] PB_NONE = 2'd0;
  localparam logic [1:0] PB_ONE  = 2'd1;
  localparam logic [1:0] PB_TWO  = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_INT,
    MODE_FRAC,
    MODE_EXP_SIGN,
    MODE_EXP_DIG,
    MODE_HEX_START,
    MODE_HEX_DIG,
    MODE_BIN_START,
    MODE_BIN_DIG,
    MODE_BAD_HEX,
    MODE_BAD_BIN,
    MODE_BAD_ZERO,
    MODE_BAD_EXP
  } scan_mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

// ===== hw/rtl/number_literal_scanner_top.sv =====
// Numeric literal scanner: one source character per transaction, token reports out.
//
// The scanner takes one character per clock cycle unless the result side
// stalls, and answers each input transaction with zero or one token report:
// kind, length and pushback count. An item passes through an input register
// and the state-update logic into a result register; a token's report is
// written there when the character that ends the token leaves the input
// register. A new character is taken in every cycle while the result side
// keeps up, since the whole state update for a character is combinational.
// A report that waits on the result side holds the character behind it in
// the input register, so the input stalls once both registers are full.
// Lengths count up to MAX_LENGTH and the report carries the low eight bits.
// When pushback is nonzero, that many trailing characters must be fed again.
module number_literal_scanner_top #(
  parameter int unsigned MAX_LENGTH = nls_pkg::MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] begin_req
  input  logic        in_tlast,   // at_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] length, [9:8] pushback, [15:10] zero
  output logic [2:0]  out_tuser   // [2:0] kind
);

  localparam int unsigned LEN_W = $clog2(MAX_LENGTH + 1);
  localparam logic [LEN_W:0] MAX_EXT = (LEN_W + 1)'(MAX_LENGTH);

  // Input register.
  logic       stg_vld_r;
  logic [7:0] stg_ch_r;
  logic       stg_begin_r;
  logic       stg_end_r;

  // Scanner state.
  nls_pkg::scan_mode_t mode_r, mode_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                seen_float_r, seen_float_nxt;
  logic                dot_pend_r, dot_pend_nxt;

  // Result register.
  logic       out_vld_r;
  logic [2:0] out_kind_r;
  logic [7:0] out_len_r;
  logic [1:0] out_pb_r;

  logic             advance;
  logic             res_vld;
  logic [2:0]       res_kind;
  logic [1:0]       res_pb;
  logic             do_dec;
  logic             dec_int;
  logic [LEN_W:0]   sum1, sum2;
  logic [LEN_W-1:0] len_inc1, len_inc2;
  logic [LEN_W+7:0] len_ext;
  logic [2:0]       dec_kind;

  assign advance   = stg_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !stg_vld_r || advance;

  assign sum1     = {1'b0, len_r} + (LEN_W + 1)'(1);
  assign sum2     = {1'b0, len_r} + (LEN_W + 1)'(2);
  assign len_inc1 = (sum1 > MAX_EXT) ? MAX_EXT[LEN_W-1:0] : sum1[LEN_W-1:0];
  assign len_inc2 = (sum2 > MAX_EXT) ? MAX_EXT[LEN_W-1:0] : sum2[LEN_W-1:0];
  assign len_ext  = {8'b0, len_r};
  assign dec_kind = seen_float_r ? nls_pkg::KIND_FLOAT : nls_pkg::KIND_INT;

  always_comb begin
    mode_nxt       = mode_r;
    len_nxt        = len_r;
    seen_float_nxt = seen_float_r;
    dot_pend_nxt   = dot_pend_r;
    res_vld        = 1'b0;
    res_kind       = nls_pkg::KIND_INT;
    res_pb         = nls_pkg::PB_NONE;
    do_dec         = 1'b0;
    dec_int        = 1'b0;

    if (stg_end_r) begin
      res_vld = 1'b1;
      case (mode_r)
        nls_pkg::MODE_ZERO, nls_pkg::MODE_INT, nls_pkg::MODE_FRAC,
        nls_pkg::MODE_EXP_SIGN, nls_pkg::MODE_EXP_DIG: begin
          res_kind = dec_kind;
          res_pb   = dot_pend_r ? nls_pkg::PB_ONE : nls_pkg::PB_NONE;
        end
        nls_pkg::MODE_HEX_START, nls_pkg::MODE_BAD_HEX: res_kind = nls_pkg::KIND_BAD_HEX;
        nls_pkg::MODE_BIN_START, nls_pkg::MODE_BAD_BIN: res_kind = nls_pkg::KIND_BAD_BIN;
        nls_pkg::MODE_HEX_DIG, nls_pkg::MODE_BIN_DIG:   res_kind = nls_pkg::KIND_INT;
        nls_pkg::MODE_BAD_ZERO:                         res_kind = nls_pkg::KIND_BAD_ZERO;
        nls_pkg::MODE_BAD_EXP:                          res_kind = nls_pkg::KIND_BAD_EXP;
        default: res_vld = 1'b0;
      endcase
    end else if (stg_begin_r) begin
      len_nxt        = LEN_W'(1);
      seen_float_nxt = 1'b0;
      dot_pend_nxt   = 1'b0;
      mode_nxt       = (stg_ch_r == nls_pkg::CH_ZERO) ? nls_pkg::MODE_ZERO : nls_pkg::MODE_INT;
    end else begin
      case (mode_r)
        nls_pkg::MODE_ZERO: begin
          if (stg_ch_r == nls_pkg::CH_LO_X || stg_ch_r == nls_pkg::CH_UP_X) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_HEX_START;
          end else if (stg_ch_r == nls_pkg::CH_LO_B || stg_ch_r == nls_pkg::CH_UP_B) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_BIN_START;
          end else if (nls_pkg::is_letter(stg_ch_r)) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_BAD_ZERO;
          end else begin
            mode_nxt = nls_pkg::MODE_INT;
            do_dec   = 1'b1;
            dec_int  = 1'b1;
          end
        end
        nls_pkg::MODE_INT: begin
          do_dec  = 1'b1;
          dec_int = 1'b1;
        end
        nls_pkg::MODE_FRAC: do_dec = 1'b1;
        nls_pkg::MODE_EXP_SIGN, nls_pkg::MODE_EXP_DIG: begin
          if (nls_pkg::is_digit(stg_ch_r) || (mode_r == nls_pkg::MODE_EXP_SIGN &&
              (stg_ch_r == nls_pkg::CH_PLUS || stg_ch_r == nls_pkg::CH_MINUS))) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_EXP_DIG;
          end else if (nls_pkg::is_alnum(stg_ch_r)) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_BAD_EXP;
          end else begin
            res_vld  = 1'b1;
            res_kind = nls_pkg::KIND_FLOAT;
            res_pb   = nls_pkg::PB_ONE;
          end
        end
        nls_pkg::MODE_HEX_START, nls_pkg::MODE_HEX_DIG: begin
          if (nls_pkg::is_hex(stg_ch_r)) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_HEX_DIG;
          end else if (nls_pkg::is_alnum(stg_ch_r)) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_BAD_HEX;
          end else begin
            res_vld  = 1'b1;
            res_kind = (mode_r == nls_pkg::MODE_HEX_START) ? nls_pkg::KIND_BAD_HEX
                                                           : nls_pkg::KIND_INT;
            res_pb   = nls_pkg::PB_ONE;
          end
        end
        nls_pkg::MODE_BIN_START, nls_pkg::MODE_BIN_DIG: begin
          if (stg_ch_r == nls_pkg::CH_ZERO || stg_ch_r == nls_pkg::CH_ONE) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_BIN_DIG;
          end else if (nls_pkg::is_alnum(stg_ch_r)) begin
            len_nxt  = len_inc1;
            mode_nxt = nls_pkg::MODE_BAD_BIN;
          end else begin
            res_vld  = 1'b1;
            res_kind = (mode_r == nls_pkg::MODE_BIN_START) ? nls_pkg::KIND_BAD_BIN
                                                           : nls_pkg::KIND_INT;
            res_pb   = nls_pkg::PB_ONE;
          end
        end
        nls_pkg::MODE_BAD_HEX, nls_pkg::MODE_BAD_BIN,
        nls_pkg::MODE_BAD_ZERO, nls_pkg::MODE_BAD_EXP: begin
          if (nls_pkg::is_alnum(stg_ch_r)) begin
            len_nxt = len_inc1;
          end else begin
            res_vld = 1'b1;
            res_pb  = nls_pkg::PB_ONE;
            case (mode_r)
              nls_pkg::MODE_BAD_HEX:  res_kind = nls_pkg::KIND_BAD_HEX;
              nls_pkg::MODE_BAD_BIN:  res_kind = nls_pkg::KIND_BAD_BIN;
              nls_pkg::MODE_BAD_ZERO: res_kind = nls_pkg::KIND_BAD_ZERO;
              default:                res_kind = nls_pkg::KIND_BAD_EXP;
            endcase
          end
        end
        default: mode_nxt = nls_pkg::MODE_IDLE;
      endcase

      // Shared decimal, fraction and exponent-start handling.
      if (do_dec) begin
        if (dot_pend_r) begin
          if (nls_pkg::is_digit(stg_ch_r)) begin
            dot_pend_nxt   = 1'b0;
            seen_float_nxt = 1'b1;
            len_nxt        = len_inc2;
            mode_nxt       = nls_pkg::MODE_FRAC;
          end else begin
            res_vld  = 1'b1;
            res_kind = dec_kind;
            res_pb   = nls_pkg::PB_TWO;
          end
        end else if (nls_pkg::is_digit(stg_ch_r)) begin
          len_nxt = len_inc1;
        end else if (dec_int && stg_ch_r == nls_pkg::CH_DOT) begin
          dot_pend_nxt = 1'b1;
        end else if (stg_ch_r == nls_pkg::CH_LO_E || stg_ch_r == nls_pkg::CH_UP_E) begin
          len_nxt        = len_inc1;
          seen_float_nxt = 1'b1;
          mode_nxt       = nls_pkg::MODE_EXP_SIGN;
        end else begin
          res_vld  = 1'b1;
          res_kind = dec_kind;
          res_pb   = nls_pkg::PB_ONE;
        end
      end
    end

    // A finished token returns the scanner to idle.
    if (res_vld) begin
      mode_nxt       = nls_pkg::MODE_IDLE;
      len_nxt        = '0;
      seen_float_nxt = 1'b0;
      dot_pend_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      stg_vld_r <= 1'b1;
    end else if (advance) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_ch_r    <= in_tdata;
      stg_begin_r <= in_tuser;
      stg_end_r   <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= nls_pkg::MODE_IDLE;
      len_r        <= '0;
      seen_float_r <= 1'b0;
      dot_pend_r   <= 1'b0;
    end else if (advance) begin
      mode_r       <= mode_nxt;
      len_r        <= len_nxt;
      seen_float_r <= seen_float_nxt;
      dot_pend_r   <= dot_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_kind_r <= res_kind;
      out_len_r  <= len_ext[7:0];
      out_pb_r   <= res_pb;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_pb_r, out_len_r};
  assign out_tuser  = out_kind_r;

endmodule

// ===== hw/rtl/nls_checker.sv =====
// Port-level checker for the numeric literal scanner and its bind statement.
module nls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A stalled report transaction must hold its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing is reported in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= nls_pkg::KIND_BAD_EXP) && (out_tdata[15:10] == 6'b0))
    else $error("bad kind code or padding");

  a_pb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:8] != 2'd3)
    else $error("pushback out of range");

  // Only a dropped dot gives two characters back, and that ends a decimal token.
  a_err_pb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != nls_pkg::KIND_INT) && (out_tuser != nls_pkg::KIND_FLOAT)
      |-> out_tdata[9:8] != nls_pkg::PB_TWO)
    else $error("error token with pushback of two");

endmodule

bind number_literal_scanner_top nls_checker u_nls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
